[rtl/rpn_pkg.sv]
// Shared types, token codes and status codes for the RPN calculator.
package rpn_pkg;

  localparam int TOP_W = 32;

  // ASCII tokens
  localparam logic [7:0] SYM_ZERO = 8'h30;
  localparam logic [7:0] SYM_NINE = 8'h39;
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_MOD  = 8'h25;

  typedef logic [2:0] status_t;

  localparam status_t STATUS_OK       = 3'd0;
  localparam status_t STATUS_SYMBOL   = 3'd1;
  localparam status_t STATUS_EMPTY    = 3'd2;
  localparam status_t STATUS_DIVZERO  = 3'd3;
  localparam status_t STATUS_RESULT   = 3'd4;
  localparam status_t STATUS_OVERFLOW = 3'd5;

  // stack action decided for the current request
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_POP  = 2'd2
  } act_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch the incoming request
    logic decode;   // classify token, latch pending action and error
    logic exec;     // operand a is on the RAM read port
    logic take;     // latch iterative unit result
    logic commit;   // update stack, load response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_op;      // operator needs the second operand
    logic op_iter;    // operator runs on the iterative unit
    logic iter_done;
    logic out_free;   // response register can take a new response
  } sts_t;

  function automatic logic sym_is_digit(input logic [7:0] s);
    return (s >= SYM_ZERO) && (s <= SYM_NINE);
  endfunction

  function automatic logic sym_is_op(input logic [7:0] s);
    return s inside {SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_MOD};
  endfunction

endpackage

[rtl/rpn_if.sv]
// Token and response channel interfaces for the RPN calculator.
interface rpn_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface rpn_result_if import rpn_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [31:0] top_value;
  logic               result_valid;

  modport source (output valid, output status, output top_value, output result_valid,
                  input ready);
  modport sink   (input valid, input status, input top_value, input result_valid,
                  output ready);
endinterface

[rtl/rpn_ram.sv]
// Generic simple dual-port RAM, one write port, registered read port.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rpn_muldiv.sv]
// Iterative shift-add multiplier and restoring signed divider, one bit per cycle.
module rpn_muldiv #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         is_mul,
  input  logic         is_mod,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CNTW = $clog2(W);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    acc;   // product or partial remainder
  logic [W-1:0]    quo;   // multiplier or dividend/quotient
  logic [W-1:0]    dvs;   // multiplicand or divisor magnitude
  logic            mul_q;
  logic            mod_q;
  logic            neg_q;
  logic            neg_r;

  logic [W-1:0] ua;
  logic [W-1:0] ub;
  logic [W-1:0] rem_sh;
  logic [W-1:0] quo_sh;

  assign ua = a[W-1] ? (W'(0) - a) : a;
  assign ub = b[W-1] ? (W'(0) - b) : b;

  // remainder stays below the divisor, so its top bit is always clear
  assign rem_sh = {acc[W-2:0], quo[W-1]};
  assign quo_sh = {quo[W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mul_q <= is_mul;
      mod_q <= is_mod;
      neg_q <= a[W-1] ^ b[W-1];
      neg_r <= a[W-1];
      acc   <= '0;
      quo   <= is_mul ? b : ua;
      dvs   <= is_mul ? a : ub;
    end else if (busy) begin
      if (mul_q) begin
        if (quo[0]) begin
          acc <= acc + dvs;
        end
        dvs <= {dvs[W-2:0], 1'b0};
        quo <= {1'b0, quo[W-1:1]};
      end else if (rem_sh >= dvs) begin
        acc <= rem_sh - dvs;
        quo <= quo_sh | W'(1);
      end else begin
        acc <= rem_sh;
        quo <= quo_sh;
      end
    end
  end

  always_comb begin
    if (mul_q) begin
      result = acc;
    end else if (mod_q) begin
      result = neg_r ? (W'(0) - acc) : acc;
    end else begin
      result = neg_q ? (W'(0) - quo) : quo;
    end
  end

endmodule

[rtl/rpn_datapath.sv]
// Datapath: stack memory, top-of-stack register, count, error and response register.
module rpn_datapath import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [7:0]         symbol,
  input  logic               last,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output status_t            rsp_status,
  output logic signed [31:0] rsp_top_value,
  output logic               rsp_result_valid
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic [7:0]    sym_q;
  logic          last_q;
  act_t          act;
  status_t       pend_err;
  logic [W-1:0]  res;
  logic [CW-1:0] count;
  status_t       err;
  logic [W-1:0]  tos;

  logic is_digit;
  logic is_op;
  logic is_mul;
  logic is_divmod;
  logic is_iter;

  act_t    dec_act;
  status_t dec_err;
  logic    dec_go;

  logic [W-1:0]  rdata;
  logic [W-1:0]  unit_result;
  logic          unit_done;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [CW-1:0] count_new;
  logic [W-1:0]  tos_new;
  status_t       st_new;
  logic          rv_new;
  logic [31:0]   top_new;

  assign is_digit  = sym_is_digit(sym_q);
  assign is_op     = sym_is_op(sym_q);
  assign is_mul    = (sym_q == SYM_MUL);
  assign is_divmod = (sym_q == SYM_DIV) || (sym_q == SYM_MOD);
  assign is_iter   = is_mul || is_divmod;

  // token classification against current stack state
  always_comb begin
    dec_act = ACT_NONE;
    dec_err = err;
    dec_go  = 1'b0;
    if (err == STATUS_OK) begin
      if (is_digit) begin
        if (count >= CW'(STACK_DEPTH)) begin
          dec_err = STATUS_OVERFLOW;
        end else begin
          dec_act = ACT_PUSH;
        end
      end else if (!is_op) begin
        dec_err = STATUS_SYMBOL;
      end else if (count < CW'(2)) begin
        dec_err = STATUS_EMPTY;
      end else if (is_divmod && (tos == '0)) begin
        dec_err = STATUS_DIVZERO;
      end else begin
        dec_act = ACT_POP;
        dec_go  = 1'b1;
      end
    end
  end

  // stack memory; read port always points at the left operand
  rpn_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (tos_new),
    .raddr (IW'(count - CW'(2))),
    .rdata (rdata)
  );

  rpn_muldiv #(
    .W (W)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.exec && is_iter),
    .is_mul (is_mul),
    .is_mod (sym_q == SYM_MOD),
    .a      (rdata),
    .b      (tos),
    .done   (unit_done),
    .result (unit_result)
  );

  // commit view of the stack after this token
  always_comb begin
    count_new = count;
    tos_new   = tos;
    wr_addr   = IW'(count);
    case (act)
      ACT_PUSH: begin
        count_new = count + CW'(1);
        tos_new   = res;
        wr_addr   = IW'(count);
      end
      ACT_POP: begin
        count_new = count - CW'(1);
        tos_new   = res;
        wr_addr   = IW'(count - CW'(2));
      end
      default: begin
      end
    endcase
    wr_en   = cmd.commit && (act != ACT_NONE);
    top_new = (count_new != '0) ? 32'(signed'(tos_new)) : '0;
    st_new  = pend_err;
    rv_new  = 1'b0;
    if (last_q && (pend_err == STATUS_OK)) begin
      if (count_new == CW'(1)) begin
        rv_new = 1'b1;
      end else begin
        st_new = STATUS_RESULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_q  <= symbol;
      last_q <= last;
    end
    if (cmd.decode) begin
      act      <= dec_act;
      pend_err <= dec_err;
      res      <= W'(sym_q[3:0]);
    end
    if (cmd.exec && !is_iter) begin
      res <= (sym_q == SYM_ADD) ? (rdata + tos) : (rdata - tos);
    end
    if (cmd.take) begin
      res <= unit_result;
    end
    if (cmd.commit) begin
      tos              <= tos_new;
      rsp_status       <= st_new;
      rsp_top_value    <= top_new;
      rsp_result_valid <= rv_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= STATUS_OK;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= last_q ? '0 : count_new;
        err       <= last_q ? STATUS_OK : pend_err;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.go_op     = dec_go;
  assign sts.op_iter   = is_iter;
  assign sts.iter_done = unit_done;
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

[rtl/rpn_ctrl.sv]
// Controller state machine sequencing one token through the datapath.
module rpn_ctrl import rpn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_ITER   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = sts.go_op ? S_READ : S_DONE;
      end
      S_READ: begin
        state_next = sts.op_iter ? S_ITER : S_DONE;
      end
      S_ITER: begin
        if (sts.iter_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no request is taken while reset is held
  assign ready      = (state == S_IDLE) && !rst;
  assign cmd.accept = ready && valid;
  assign cmd.decode = (state == S_DECODE);
  assign cmd.exec   = (state == S_READ);
  assign cmd.take   = (state == S_ITER) && sts.iter_done;
  assign cmd.commit = (state == S_DONE) && sts.out_free;

endmodule

[rtl/rpn_stack_calculator.sv]
// RPN stack calculator top level: controller, datapath and channel wiring.
// After request accept a digit, an error or a pending error goes decode -> commit,
// + and - add an operand read, and * / and % add the operand read and iterate states.
// One request in flight: the next is taken the cycle after the response register
// loads, and a stalled response holds off the commit and so the next request.
// Synchronous active-high reset empties the stack, clears the error and the response.
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  rpn_token_if.sink   tokens,
  rpn_result_if.source results
);

  cmd_t cmd;
  sts_t sts;

  // Controller walks idle -> decode -> (operand read -> iterate) -> commit.
  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (tokens.valid),
    .ready (tokens.ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath keeps the top of stack in a register and the whole stack in RAM,
  // so an operator needs only one RAM read for its left operand.
  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .symbol           (tokens.symbol),
    .last             (tokens.last),
    .rsp_valid        (results.valid),
    .rsp_ready        (results.ready),
    .rsp_status       (results.status),
    .rsp_top_value    (results.top_value),
    .rsp_result_valid (results.result_valid)
  );

endmodule

[rtl/rpn_checker.sv]
// Port-level assertions for the RPN calculator, bound to the top level.
module rpn_checker import rpn_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               tok_valid,
  input logic               tok_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input status_t            rsp_status,
  input logic signed [31:0] rsp_top_value,
  input logic               rsp_result_valid
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_top_value) && $stable(rsp_result_valid))
    else $error("response changed while stalled");

  // a reported result always carries ok status
  a_result_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_result_valid |-> rsp_status == STATUS_OK)
    else $error("result flagged with error status");

  // one request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready |=> !tok_ready)
    else $error("second request taken while busy");

  // reset leaves no response pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind rpn_stack_calculator rpn_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .tok_valid        (tokens.valid),
  .tok_ready        (tokens.ready),
  .rsp_valid        (results.valid),
  .rsp_ready        (results.ready),
  .rsp_status       (results.status),
  .rsp_top_value    (results.top_value),
  .rsp_result_valid (results.result_valid)
);

[dv/tb_rpn_stack_calculator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RPN stack calculator: token driver, response monitor, predictor.
module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  localparam int DEPTH        = 64;     // stack entries, matches the DUT setting below
  localparam int N_ITEMS      = 1875;   // directed and corner tokens plus about 1540 random ones
  localparam int HOLD_AT_RESP = 150;    // response count at which the sink stops taking
  localparam int HOLD_CYCLES  = 500;    // length of that stall
  localparam int DRAIN_CYCLES = 80;     // quiet time after the last response

  typedef struct {
    logic [7:0] symbol;
    logic       last;
  } token_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] top_value;
    logic               result_valid;
  } resp_t;

  logic clk;
  logic rst;

  rpn_token_if  tokens ();
  rpn_result_if results ();

  rpn_stack_calculator #(
    .STACK_DEPTH (DEPTH),
    .VALUE_WIDTH (32)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .tokens  (tokens),
    .results (results)
  );

  // 2 ns period, first rising edge at 1 ns
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the value stack, the fill count and the
  // sticky error. Only entries below calc_depth are ever read.
  // ---------------------------------------------------------------------------
  logic signed [31:0] calc_stack [DEPTH];
  int                 calc_depth = 0;
  status_t            calc_err   = STATUS_OK;

  token_t pending_tokens [$];   // requests still to be offered
  resp_t  expected_resp  [$];   // predicted responses, oldest first

  // handshake flags: set at the rising edge by the monitor, consumed at the falling edge
  bit     tok_fire  = 1'b0;
  bit     resp_fire = 1'b0;
  bit     drv_busy  = 1'b0;
  bit     drv_burst = 1'b0;
  bit     rcv_burst = 1'b0;
  int     drv_gap   = 0;
  int     rcv_gap   = 0;
  int     hold_left = 0;
  token_t drv_tok;

  int unsigned n_fail  = 0;
  int unsigned n_tok   = 0;
  int unsigned n_resp  = 0;
  int unsigned n_valid = 0;
  int unsigned status_seen [8];

  // Evaluate one token against the predictor state and return the response it
  // should produce. A pending error freezes the stack; a failing token leaves it
  // as it was; a last token reports and then empties everything.
  function automatic resp_t rpn_eval_token(input logic [7:0] sym, input logic last_tok);
    resp_t              r;
    status_t            st;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] res;
    longint             wa;
    longint             wb;
    st = calc_err;
    if (st == STATUS_OK) begin
      if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
        if (calc_depth >= DEPTH) begin
          st = STATUS_OVERFLOW;
        end else begin
          calc_stack[calc_depth] = 32'(sym - SYM_ZERO);
          calc_depth++;
        end
      end else if (!(sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL ||
                     sym == SYM_DIV || sym == SYM_MOD)) begin
        st = STATUS_SYMBOL;
      end else if (calc_depth < 2) begin
        st = STATUS_EMPTY;
      end else begin
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        if ((sym == SYM_DIV || sym == SYM_MOD) && b == 0) begin
          st = STATUS_DIVZERO;
        end else begin
          // 64-bit signed math truncates toward zero; most negative / -1
          // comes back as +2^31 and wraps to the most negative value
          wa = a;
          wb = b;
          case (sym)
            SYM_ADD: res = a + b;
            SYM_SUB: res = a - b;
            SYM_MUL: res = a * b;
            SYM_DIV: res = 32'(wa / wb);
            default: res = 32'(wa % wb);
          endcase
          calc_stack[calc_depth-2] = res;
          calc_depth--;
        end
      end
    end
    calc_err       = st;
    r.status       = st;
    r.top_value    = (calc_depth > 0) ? calc_stack[calc_depth-1] : 32'sd0;
    r.result_valid = 1'b0;
    if (last_tok) begin
      if (r.status == STATUS_OK) begin
        if (calc_depth == 1) r.result_valid = 1'b1;
        else r.status = STATUS_RESULT;
      end
      calc_depth = 0;
      calc_err   = STATUS_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_token(input logic [7:0] sym, input logic last_tok);
    token_t t;
    t.symbol = sym;
    t.last   = last_tok;
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  function automatic logic [7:0] digit_sym(input int d);
    return 8'(SYM_ZERO + d);
  endfunction

  function automatic logic [7:0] rand_digit();
    return digit_sym($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return SYM_ADD;
      1: return SYM_SUB;
      2: return SYM_MUL;
      3: return SYM_DIV;
      default: return SYM_MOD;
    endcase
  endfunction

  // Well-formed expression with n_digits operands: operators are interleaved at
  // random, never more than the stack holds, and the final token reduces to one value.
  function automatic void gen_expression(input int n_digits);
    int depth;
    int left;
    depth = 0;
    left  = n_digits;
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || depth >= DEPTH || $urandom_range(0, 1) == 1)) begin
        depth--;
        add_token(rand_op(), left == 0 && depth == 1);
      end else begin
        depth++;
        left--;
        add_token(rand_digit(), left == 0 && depth == 1);
      end
    end
  endfunction

  // Broken sequence: digits, operators and arbitrary bytes, with stray last marks.
  function automatic void gen_noise(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      add_token((k < 4) ? rand_digit() : (k < 7) ? rand_op() : 8'($urandom_range(0, 255)),
                (i == n - 1) || ($urandom_range(0, 15) == 0));
    end
  endfunction

  // Push n digits, then reduce. More than DEPTH pushes overflows, and the
  // remaining operators then run against the sticky error.
  function automatic void gen_deep(input int n);
    for (int i = 0; i < n; i++) add_token(rand_digit(), 1'b0);
    for (int i = 1; i < n; i++) add_token(rand_op(), i == n - 1);
  endfunction

  // Build 8^10 * 2 = 2^31, which wraps to the most negative value, then apply
  // op against -divisor (divisor 1 gives the most negative over minus one case).
  function automatic void gen_min_div(input logic [7:0] op, input int divisor);
    add_token(digit_sym(8), 1'b0);
    repeat (9) begin
      add_token(digit_sym(8), 1'b0);
      add_token(SYM_MUL, 1'b0);
    end
    add_token(digit_sym(2), 1'b0);
    add_token(SYM_MUL, 1'b0);
    add_token(digit_sym(0), 1'b0);
    add_token(digit_sym(divisor), 1'b0);
    add_token(SYM_SUB, 1'b0);
    add_token(op, 1'b1);
  endfunction

  // Idle gap drawn after each accepted request or response; burst mode flips now and then and
  // gives stretches with no idling at all.
  function automatic int idle_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // ---------------------------------------------------------------------------
  // Token driver: changes inputs on the falling edge, one nonblocking write of
  // valid per step. After an accept it draws the gap before the next request.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      tokens.valid <= 1'b0;
    end else begin
      if (tok_fire) begin
        tok_fire = 1'b0;
        drv_busy = 1'b0;
        drv_gap  = idle_gap(drv_burst);
      end
      if (!drv_busy && drv_gap > 0) begin
        drv_gap--;
      end else if (!drv_busy && pending_tokens.size() != 0) begin
        drv_tok  = pending_tokens.pop_front();
        drv_busy = 1'b1;
        tokens.symbol <= drv_tok.symbol;
        tokens.last   <= drv_tok.last;
      end
      tokens.valid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Response sink: ready drops for a random gap after each accepted response,
  // and once for a long stall while the driver keeps offering, so the block
  // backs up into its token input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (resp_fire) begin
        resp_fire = 1'b0;
        rcv_gap   = idle_gap(rcv_burst);
        if (n_resp == HOLD_AT_RESP) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Responses are checked
  // before the token of the same edge is predicted; a response can only belong
  // to an earlier request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst) begin
      if (results.valid && results.ready) begin
        resp_fire = 1'b1;
        n_resp++;
        if (expected_resp.size() == 0) begin
          $error("response with no request outstanding: status %0d top_value %0d",
                 results.status, results.top_value);
          n_fail++;
        end else begin
          exp_r = expected_resp.pop_front();
          status_seen[exp_r.status]++;
          if (exp_r.result_valid) n_valid++;
          if (results.status !== exp_r.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_r.status, results.status);
            n_fail++;
          end
          if (results.top_value !== exp_r.top_value) begin
            $error("top_value mismatch: expected %0d, actual %0d",
                   exp_r.top_value, results.top_value);
            n_fail++;
          end
          if (results.result_valid !== exp_r.result_valid) begin
            $error("result_valid mismatch: expected %0d, actual %0d",
                   exp_r.result_valid, results.result_valid);
            n_fail++;
          end
        end
      end
      if (tokens.valid && tokens.ready) begin
        tok_fire = 1'b1;
        n_tok++;
        expected_resp.insert(expected_resp.size(),
                             rpn_eval_token(tokens.symbol, tokens.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    tokens.valid   = 1'b0;
    tokens.symbol  = 8'h00;
    tokens.last    = 1'b0;
    results.ready  = 1'b0;

    // directed: digit extremes as whole expressions
    add_token(digit_sym(9), 1'b1);
    add_token(digit_sym(0), 1'b1);
    // every operator in one chain: ((9+4)*3-2)/5 % 4 = 3
    add_token(digit_sym(9), 1'b0);
    add_token(digit_sym(4), 1'b0);
    add_token(SYM_ADD, 1'b0);
    add_token(digit_sym(3), 1'b0);
    add_token(SYM_MUL, 1'b0);
    add_token(digit_sym(2), 1'b0);
    add_token(SYM_SUB, 1'b0);
    add_token(digit_sym(5), 1'b0);
    add_token(SYM_DIV, 1'b0);
    add_token(digit_sym(4), 1'b0);
    add_token(SYM_MOD, 1'b1);
    // operator on an empty stack, alone on a last token
    add_token(SYM_ADD, 1'b1);
    // too few operands, then tokens swallowed by the pending error
    add_token(digit_sym(5), 1'b0);
    add_token(SYM_MUL, 1'b0);
    add_token(digit_sym(3), 1'b0);
    add_token(SYM_ADD, 1'b1);
    // zero divisor on both division operators
    add_token(digit_sym(6), 1'b0);
    add_token(digit_sym(0), 1'b0);
    add_token(SYM_DIV, 1'b1);
    add_token(digit_sym(6), 1'b0);
    add_token(digit_sym(0), 1'b0);
    add_token(SYM_MOD, 1'b1);
    // unknown symbols at both byte extremes
    add_token(8'h00, 1'b1);
    add_token(8'hFF, 1'b1);
    // two values left at the end
    add_token(digit_sym(1), 1'b0);
    add_token(digit_sym(2), 1'b1);

    // long corner sequences first: most negative over minus one, full stack,
    // overflow
    gen_min_div(SYM_DIV, 1);
    gen_min_div(SYM_MOD, 1);
    gen_deep(DEPTH);
    gen_deep(DEPTH + 1);

    // random mix, mostly well-formed expressions
    while (pending_tokens.size() < N_ITEMS) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_expression(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 9));
      end else if (pick < 94) begin
        gen_noise($urandom_range(1, 8));
      end else if (pick < 96) begin
        gen_min_div(($urandom_range(0, 1) == 0) ? SYM_DIV : SYM_MOD, $urandom_range(1, 9));
      end else if (pick < 97) begin
        gen_deep($urandom_range(DEPTH - 2, DEPTH + 2));
      end else begin
        add_token(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_tokens.size() != 0 || drv_busy || expected_resp.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d tokens, %0d responses, %0d completed results.",
             n_tok, n_resp, n_valid);
    $display("Errors seen: symbol %0d, empty %0d, div-by-zero %0d, bad result %0d, overflow %0d.",
             status_seen[STATUS_SYMBOL], status_seen[STATUS_EMPTY],
             status_seen[STATUS_DIVZERO], status_seen[STATUS_RESULT],
             status_seen[STATUS_OVERFLOW]);
    if (n_fail == 0) begin
      $display("rpn_stack_calculator regression: pass");
    end else begin
      $display("rpn_stack_calculator regression: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("rpn_stack_calculator regression: fail");
    $finish;
  end

endmodule
